### src/bts_pkg.sv
// Shared types, constants and helper functions for the bilinear texel sampler.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int STORE_DEPTH = 65536;
  localparam int WEIGHT_BITS = 16;

  localparam int CFG_W     = 9;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int SIDE_CW   = SIDE_W + 1;
  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int IN_ADDR_W = 16;
  localparam int COORD_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int P_W       = COORD_W + SIDE_W;
  localparam int RB_W      = SIDE_W + SIDE_CW;
  localparam int AS_W      = RB_W + 1;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int NUM_TAPS  = 4;
  localparam int LERP_W    = WEIGHT_BITS + CH_W + 2;
  localparam int SUM_W     = LERP_W + WEIGHT_BITS + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(1) << FRAC_W;
  localparam logic [CFG_W-1:0]   SIDE_RESET = CFG_W'(MAX_SIDE);

  // channel slots inside a pixel
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // neighbor taps
  localparam int TAP_00 = 0;
  localparam int TAP_10 = 1;
  localparam int TAP_01 = 2;
  localparam int TAP_11 = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ROW_PITCH    = 2'd2
  } cfg_reg_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    op_t                     op;
    logic [ADDR_W-1:0]       waddr;
    pix_t                    wpix;
    logic [SIDE_W-1:0]       u0;
    logic [SIDE_W-1:0]       u1;
    logic [SIDE_W-1:0]       v0;
    logic [SIDE_W-1:0]       v1;
    logic [WEIGHT_BITS-1:0]  wu;
    logic [WEIGHT_BITS-1:0]  wv;
  } q_item_t;

  function automatic logic [SIDE_CW-1:0] clamp_side(input logic [CFG_W-1:0] s);
    logic [SIDE_CW-1:0] r;
    if (s == '0) begin
      r = SIDE_CW'(1);
    end else if (int'(s) > MAX_SIDE) begin
      r = SIDE_CW'(MAX_SIDE);
    end else begin
      r = SIDE_CW'(s);
    end
    return r;
  endfunction

  // fraction rescaled to the weight width
  function automatic logic [WEIGHT_BITS-1:0] to_weight(input logic [FRAC_W-1:0] f);
    logic [WEIGHT_BITS+FRAC_W-1:0] t;
    t = {f, {WEIGHT_BITS{1'b0}}};
    return t[WEIGHT_BITS+FRAC_W-1:FRAC_W];
  endfunction

endpackage

### src/bts_front.sv
// Front end: accepts requests, saturates and scales coordinates, splits indices and weights.
`timescale 1ns / 1ps

module bts_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bts_pkg::op_t                    in_op,
  input  logic [bts_pkg::IN_ADDR_W-1:0]   in_addr,
  input  bts_pkg::pix_t                   in_pix,
  input  logic [bts_pkg::COORD_W-1:0]     in_u,
  input  logic [bts_pkg::COORD_W-1:0]     in_v,
  input  logic [bts_pkg::SIDE_CW-1:0]     width_side,
  input  logic [bts_pkg::SIDE_CW-1:0]     height_side,
  output logic                            q_valid,
  input  logic                            q_ready,
  output bts_pkg::q_item_t                q_item
);

  logic                           f1_valid_r;
  bts_pkg::op_t                   f1_op_r;
  logic [bts_pkg::ADDR_W-1:0]     f1_waddr_r;
  bts_pkg::pix_t                  f1_pix_r;
  logic [bts_pkg::P_W-1:0]        f1_pu_r;
  logic [bts_pkg::P_W-1:0]        f1_pv_r;

  logic [bts_pkg::SIDE_W-1:0]     smu;
  logic [bts_pkg::SIDE_W-1:0]     smv;
  logic [bts_pkg::COORD_W-1:0]    u_sat;
  logic [bts_pkg::COORD_W-1:0]    v_sat;
  logic [bts_pkg::P_W-1:0]        pu_nxt;
  logic [bts_pkg::P_W-1:0]        pv_nxt;
  logic [bts_pkg::SIDE_W:0]       bu_raw;
  logic [bts_pkg::SIDE_W:0]       bv_raw;
  logic [bts_pkg::SIDE_W-1:0]     u0;
  logic [bts_pkg::SIDE_W-1:0]     v0;

  assign smu = bts_pkg::SIDE_W'(width_side - 1'b1);
  assign smv = bts_pkg::SIDE_W'(height_side - 1'b1);

  assign u_sat = (in_u > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE : in_u;
  assign v_sat = (in_v > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE : in_v;

  assign pu_nxt = bts_pkg::P_W'(u_sat) * bts_pkg::P_W'(smu);
  assign pv_nxt = bts_pkg::P_W'(v_sat) * bts_pkg::P_W'(smv);

  assign in_ready = !f1_valid_r || q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (in_ready) begin
      f1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f1_op_r    <= in_op;
      f1_waddr_r <= bts_pkg::ADDR_W'(in_addr);
      f1_pix_r   <= in_pix;
      f1_pu_r    <= pu_nxt;
      f1_pv_r    <= pv_nxt;
    end
  end

  // base index is clamped to the last column/row, next index likewise
  assign bu_raw = f1_pu_r[bts_pkg::P_W-1:bts_pkg::FRAC_W];
  assign bv_raw = f1_pv_r[bts_pkg::P_W-1:bts_pkg::FRAC_W];
  assign u0 = (bu_raw > {1'b0, smu}) ? smu : bu_raw[bts_pkg::SIDE_W-1:0];
  assign v0 = (bv_raw > {1'b0, smv}) ? smv : bv_raw[bts_pkg::SIDE_W-1:0];

  always_comb begin
    q_item.op    = f1_op_r;
    q_item.waddr = f1_waddr_r;
    q_item.wpix  = f1_pix_r;
    q_item.u0    = u0;
    q_item.u1    = (u0 == smu) ? smu : u0 + 1'b1;
    q_item.v0    = v0;
    q_item.v1    = (v0 == smv) ? smv : v0 + 1'b1;
    q_item.wu    = bts_pkg::to_weight(f1_pu_r[bts_pkg::FRAC_W-1:0]);
    q_item.wv    = bts_pkg::to_weight(f1_pv_r[bts_pkg::FRAC_W-1:0]);
  end

  assign q_valid = f1_valid_r;

endmodule

### src/bts_queue.sv
// Short first-word-fall-through queue between the front and back ends.
`timescale 1ns / 1ps

module bts_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  bts_pkg::q_item_t  wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output bts_pkg::q_item_t  rd_item
);

  localparam int PTR_W = $clog2(bts_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bts_pkg::QUEUE_DEPTH + 1);

  bts_pkg::q_item_t   mem_r [bts_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               push;
  logic               pop;

  assign wr_ready = (cnt_r != CNT_W'(bts_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

### src/bts_texel_ram.sv
// One-write, one-read texel store with registered read data.
`timescale 1ns / 1ps

module bts_texel_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bts_pkg::ADDR_W-1:0]  waddr,
  input  bts_pkg::pix_t               wdata,
  input  logic [bts_pkg::ADDR_W-1:0]  raddr,
  output bts_pkg::pix_t               rdata
);

  bts_pkg::pix_t mem [bts_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/bts_back.sv
// Back end: address generation, four-tap store read, two-pass lerp, output FIFO.
`timescale 1ns / 1ps

module bts_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  bts_pkg::q_item_t               q_item,
  input  logic [bts_pkg::SIDE_CW-1:0]    pitch_side,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bts_pkg::pix_t                  out_pix
);

  localparam int UC_W  = $clog2(bts_pkg::OUT_DEPTH + 1);
  localparam int OP_W  = $clog2(bts_pkg::OUT_DEPTH);
  localparam int WB    = bts_pkg::WEIGHT_BITS;

  // issue / credit
  logic [UC_W-1:0]  used_r;
  logic             credit_ok;
  logic             q_pop;
  logic             issue_smp;
  logic             issue_wr;

  // stage 1
  logic                          s1_smp_r;
  logic                          s1_wr_r;
  logic [bts_pkg::RB_W-1:0]      s1_row0_r;
  logic [bts_pkg::RB_W-1:0]      s1_row1_r;
  logic [bts_pkg::SIDE_W-1:0]    s1_u0_r;
  logic [bts_pkg::SIDE_W-1:0]    s1_u1_r;
  logic [WB-1:0]                 s1_wu_r;
  logic [WB-1:0]                 s1_wv_r;
  logic [bts_pkg::ADDR_W-1:0]    s1_waddr_r;
  bts_pkg::pix_t                 s1_wpix_r;

  // stage 2 (store read)
  logic [bts_pkg::ADDR_W-1:0]    raddr [bts_pkg::NUM_TAPS];
  bts_pkg::pix_t                 tex   [bts_pkg::NUM_TAPS];
  logic                          s2_smp_r;
  logic [WB-1:0]                 s2_wu_r;
  logic [WB-1:0]                 s2_wv_r;

  // stage 3 (lerp along u)
  logic signed [bts_pkg::CH_W:0]     dtop    [bts_pkg::NUM_CH];
  logic signed [bts_pkg::CH_W:0]     dbot    [bts_pkg::NUM_CH];
  logic signed [bts_pkg::LERP_W-1:0] top_nxt [bts_pkg::NUM_CH];
  logic signed [bts_pkg::LERP_W-1:0] bot_nxt [bts_pkg::NUM_CH];
  logic signed [bts_pkg::LERP_W-1:0] s3_top_r [bts_pkg::NUM_CH];
  logic signed [bts_pkg::LERP_W-1:0] s3_bot_r [bts_pkg::NUM_CH];
  logic                              s3_smp_r;
  logic [WB-1:0]                     s3_wv_r;

  // stage 4 (lerp along v)
  logic signed [bts_pkg::LERP_W-1:0] dv      [bts_pkg::NUM_CH];
  logic signed [bts_pkg::SUM_W-1:0]  sum_nxt [bts_pkg::NUM_CH];
  logic signed [bts_pkg::SUM_W-1:0]  s4_sum_r [bts_pkg::NUM_CH];
  logic                              s4_smp_r;
  logic [bts_pkg::SUM_W-1:0]         rsum    [bts_pkg::NUM_CH];
  bts_pkg::pix_t                     res_pix;

  // output FIFO
  bts_pkg::pix_t     fifo_r [bts_pkg::OUT_DEPTH];
  logic [OP_W-1:0]   fwr_ptr_r;
  logic [OP_W-1:0]   frd_ptr_r;
  logic [UC_W-1:0]   fcnt_r;
  logic              fpush;
  logic              fpop;

  // a sample is issued only when the FIFO has room reserved for its result
  assign credit_ok = (used_r < UC_W'(bts_pkg::OUT_DEPTH));
  assign q_ready   = (q_item.op == bts_pkg::OP_WRITE) || credit_ok;
  assign q_pop     = q_valid && q_ready;
  assign issue_smp = q_pop && (q_item.op == bts_pkg::OP_SAMPLE);
  assign issue_wr  = q_pop && (q_item.op == bts_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      s1_smp_r <= 1'b0;
      s1_wr_r  <= 1'b0;
      s2_smp_r <= 1'b0;
      s3_smp_r <= 1'b0;
      s4_smp_r <= 1'b0;
    end else begin
      used_r   <= used_r + UC_W'(issue_smp) - UC_W'(fpop);
      s1_smp_r <= issue_smp;
      s1_wr_r  <= issue_wr;
      s2_smp_r <= s1_smp_r;
      s3_smp_r <= s2_smp_r;
      s4_smp_r <= s3_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_row0_r  <= bts_pkg::RB_W'(q_item.v0) * bts_pkg::RB_W'(pitch_side);
    s1_row1_r  <= bts_pkg::RB_W'(q_item.v1) * bts_pkg::RB_W'(pitch_side);
    s1_u0_r    <= q_item.u0;
    s1_u1_r    <= q_item.u1;
    s1_wu_r    <= q_item.wu;
    s1_wv_r    <= q_item.wv;
    s1_waddr_r <= q_item.waddr;
    s1_wpix_r  <= q_item.wpix;
  end

  // addresses wrap at the store depth
  assign raddr[bts_pkg::TAP_00] = bts_pkg::ADDR_W'({1'b0, s1_row0_r} + bts_pkg::AS_W'(s1_u0_r));
  assign raddr[bts_pkg::TAP_10] = bts_pkg::ADDR_W'({1'b0, s1_row0_r} + bts_pkg::AS_W'(s1_u1_r));
  assign raddr[bts_pkg::TAP_01] = bts_pkg::ADDR_W'({1'b0, s1_row1_r} + bts_pkg::AS_W'(s1_u0_r));
  assign raddr[bts_pkg::TAP_11] = bts_pkg::ADDR_W'({1'b0, s1_row1_r} + bts_pkg::AS_W'(s1_u1_r));

  // one copy of the store per tap, all written together
  for (genvar t = 0; t < bts_pkg::NUM_TAPS; t++) begin : g_tap
    bts_texel_ram u_ram (
      .clk   (clk),
      .we    (s1_wr_r),
      .waddr (s1_waddr_r),
      .wdata (s1_wpix_r),
      .raddr (raddr[t]),
      .rdata (tex[t])
    );
  end

  always_ff @(posedge clk) begin
    s2_wu_r <= s1_wu_r;
    s2_wv_r <= s1_wv_r;
  end

  always_comb begin
    for (int c = 0; c < bts_pkg::NUM_CH; c++) begin
      dtop[c] = $signed({1'b0, tex[bts_pkg::TAP_10][c]}) - $signed({1'b0, tex[bts_pkg::TAP_00][c]});
      dbot[c] = $signed({1'b0, tex[bts_pkg::TAP_11][c]}) - $signed({1'b0, tex[bts_pkg::TAP_01][c]});
      top_nxt[c] = $signed({2'b00, tex[bts_pkg::TAP_00][c], {WB{1'b0}}})
                   + $signed({1'b0, s2_wu_r}) * dtop[c];
      bot_nxt[c] = $signed({2'b00, tex[bts_pkg::TAP_01][c], {WB{1'b0}}})
                   + $signed({1'b0, s2_wu_r}) * dbot[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < bts_pkg::NUM_CH; c++) begin
      s3_top_r[c] <= top_nxt[c];
      s3_bot_r[c] <= bot_nxt[c];
    end
    s3_wv_r <= s2_wv_r;
  end

  always_comb begin
    for (int c = 0; c < bts_pkg::NUM_CH; c++) begin
      dv[c]      = s3_bot_r[c] - s3_top_r[c];
      sum_nxt[c] = (bts_pkg::SUM_W'(s3_top_r[c]) <<< WB) + $signed({1'b0, s3_wv_r}) * dv[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < bts_pkg::NUM_CH; c++) begin
      s4_sum_r[c] <= sum_nxt[c];
    end
  end

  // round half up, then drop the weight fraction bits
  always_comb begin
    for (int c = 0; c < bts_pkg::NUM_CH; c++) begin
      rsum[c]    = $unsigned(s4_sum_r[c]) + (bts_pkg::SUM_W'(1) << (2 * WB - 1));
      res_pix[c] = rsum[c][2 * WB +: bts_pkg::CH_W];
    end
  end

  assign fpush     = s4_smp_r;
  assign out_valid = (fcnt_r != '0);
  assign fpop      = out_valid && out_ready;
  assign out_pix   = fifo_r[frd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwr_ptr_r <= '0;
      frd_ptr_r <= '0;
      fcnt_r    <= '0;
    end else begin
      if (fpush) begin
        fwr_ptr_r <= fwr_ptr_r + 1'b1;
      end
      if (fpop) begin
        frd_ptr_r <= frd_ptr_r + 1'b1;
      end
      fcnt_r <= fcnt_r + UC_W'(fpush) - UC_W'(fpop);
    end
  end

  always_ff @(posedge clk) begin
    if (fpush) begin
      fifo_r[fwr_ptr_r] <= res_pix;
    end
  end

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fpush |-> (fcnt_r < UC_W'(bts_pkg::OUT_DEPTH)))
    else $error("output FIFO written while full");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UC_W'(bts_pkg::OUT_DEPTH))
    else $error("credit count above FIFO depth");

  a_credit_covers_fifo: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= used_r)
    else $error("FIFO holds results with no reserved credit");

  a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
    issue_smp |=> ##3 s4_smp_r)
    else $error("issued sample lost in the pipeline");

endmodule

### src/bilinear_rgb_texel_sampler.sv
// Top level of the bilinear RGB888 texel sampler.
//
// Usage:
//   Input stream (in_*): in_tuser selects the request kind: 0 writes one texel
//   at texel_address, 1 samples at (coord_u, coord_v) in unsigned Q1.16.
//   Output stream (out_*): one interpolated RGB888 result per sample request;
//   write requests produce nothing.
//   Configuration (cfg_*): image width, image height and row pitch, written
//   with cfg_we while the block is idle. Index 3 is ignored.
// Throughput: one request per cycle, sustained while out_tready stays high, writes and samples mixed.
// Sample path: a sample passes the front register, queue, address multiply, store read,
//   u lerp and v lerp registers and then the output FIFO before out_tvalid shows it.
// Reset: control state clears, size registers return to 256. The texel store
//   is not cleared; every texel must be written before a sample touches it.
// Stalls: results wait in an eight-entry output FIFO; samples are issued only
//   against free FIFO slots, so a stalled receiver fills the FIFO and the
//   four-entry queue, and then in_tready falls. Writes queued ahead of the
//   first waiting sample still drain.
`timescale 1ns / 1ps

module bilinear_rgb_texel_sampler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // texel_address, texel_red, texel_green, texel_blue, coord_u, coord_v, pad
  input  logic [79:0]                in_tdata,
  // operation
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_red, out_green, out_blue
  output logic [23:0]                out_tdata,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [bts_pkg::CFG_W-1:0]    width_r;
  logic [bts_pkg::CFG_W-1:0]    height_r;
  logic [bts_pkg::CFG_W-1:0]    pitch_r;
  logic [bts_pkg::SIDE_CW-1:0]  width_side;
  logic [bts_pkg::SIDE_CW-1:0]  height_side;
  logic [bts_pkg::SIDE_CW-1:0]  pitch_side;

  bts_pkg::op_t                 in_op;
  bts_pkg::pix_t                in_pix;

  logic                         fq_valid;
  logic                         fq_ready;
  bts_pkg::q_item_t             fq_item;
  logic                         qb_valid;
  logic                         qb_ready;
  bts_pkg::q_item_t             qb_item;
  bts_pkg::pix_t                res_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bts_pkg::SIDE_RESET;
      height_r <= bts_pkg::SIDE_RESET;
      pitch_r  <= bts_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bts_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        bts_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        bts_pkg::REG_ROW_PITCH:    pitch_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign width_side  = bts_pkg::clamp_side(width_r);
  assign height_side = bts_pkg::clamp_side(height_r);
  assign pitch_side  = bts_pkg::clamp_side(pitch_r);

  assign in_op = bts_pkg::op_t'(in_tuser);
  assign in_pix[bts_pkg::CH_RED]   = in_tdata[23:16];
  assign in_pix[bts_pkg::CH_GREEN] = in_tdata[31:24];
  assign in_pix[bts_pkg::CH_BLUE]  = in_tdata[39:32];

  bts_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_op),
    .in_addr     (in_tdata[15:0]),
    .in_pix      (in_pix),
    .in_u        (in_tdata[56:40]),
    .in_v        (in_tdata[73:57]),
    .width_side  (width_side),
    .height_side (height_side),
    .q_valid     (fq_valid),
    .q_ready     (fq_ready),
    .q_item      (fq_item)
  );

  bts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  bts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .pitch_side (pitch_side),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pix    (res_pix)
  );

  assign out_tdata = {res_pix[bts_pkg::CH_BLUE], res_pix[bts_pkg::CH_GREEN],
                      res_pix[bts_pkg::CH_RED]};

endmodule
